FILE: hw/rtl/sdas_pkg.sv
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared constants, types and helper functions of the signed decimal unit.
// ----------------------------------------------------------------------------
package sdas_pkg;

    localparam int DIGITS    = 64;
    localparam int NIB_W     = 4;
    localparam int WORD_DIG  = 16;
    localparam int WORD_W    = WORD_DIG * NIB_W;
    localparam int WORDS     = DIGITS / WORD_DIG;
    localparam int MAG_W     = DIGITS * NIB_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DCNT_W    = $clog2(DIGITS);
    localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;

    typedef enum logic [2:0] {
        ALU_ADD = 3'b001,
        ALU_SUB = 3'b010,
        ALU_MUL = 3'b100
    } alu_op_t;

    typedef struct packed {
        logic [NIB_W-1:0] digit;
        logic [NIB_W-1:0] carry;
    } alu_res_t;

    function automatic logic word_has_bad(input logic [WORD_W-1:0] w);
        logic bad;
        bad = 1'b0;
        for (int i = 0; i < WORD_DIG; i++) begin
            if (w[i*NIB_W +: NIB_W] > 4'd9) begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

    // Quotient by ten through a reciprocal multiply, exact for every 8-bit input.
    function automatic logic [4:0] div10(input logic [7:0] t);
        logic [15:0] p;
        p = {8'd0, t} * 16'd205;
        return p[15:11];
    endfunction

endpackage

FILE: hw/rtl/sdas_in_if.sv
// ----------------------------------------------------------------------------
// sdas_in_if
// Operand word channel: valid/ready handshake with one operand word each.
// ----------------------------------------------------------------------------
interface sdas_in_if import sdas_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [WORD_W-1:0]   digits_a;
    logic [WORD_W-1:0]   digits_b;
    logic                sign_a;
    logic                sign_b;
    logic                last_word;

    modport source (output valid, command, digits_a, digits_b, sign_a, sign_b, last_word,
                    input ready);
    modport sink   (input valid, command, digits_a, digits_b, sign_a, sign_b, last_word,
                    output ready);
endinterface

FILE: hw/rtl/sdas_out_if.sv
// ----------------------------------------------------------------------------
// sdas_out_if
// Result word channel: valid/ready handshake with one result word each.
// ----------------------------------------------------------------------------
interface sdas_out_if import sdas_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   result_digits;
    logic                result_sign;
    logic                overflow;
    logic                bad_digit;
    logic                last_result;

    modport source (output valid, result_digits, result_sign, overflow, bad_digit,
                    last_result, input ready);
    modport sink   (input valid, result_digits, result_sign, overflow, bad_digit,
                    last_result, output ready);
endinterface

FILE: hw/rtl/sdas_digit_alu.sv
// ----------------------------------------------------------------------------
// sdas_digit_alu
// One decimal digit step: add with carry, subtract with borrow, or
// multiply-accumulate a digit product into a partial sum digit.
// ----------------------------------------------------------------------------
module sdas_digit_alu
    import sdas_pkg::*;
(
    input  alu_op_t          op,
    input  logic [NIB_W-1:0] a,
    input  logic [NIB_W-1:0] b,
    input  logic [NIB_W-1:0] acc,
    input  logic [NIB_W-1:0] cin,
    output alu_res_t         res
);

    logic [7:0] prod;
    logic [7:0] sum;
    logic [4:0] quot;
    logic [7:0] rem;
    logic [4:0] sub_y;

    assign prod  = {4'd0, a} * {4'd0, b};
    assign sub_y = {1'b0, b} + {1'b0, cin};

    always_comb
    begin
        unique case (op)
            ALU_MUL: sum = prod + {4'd0, acc} + {4'd0, cin};
            default: sum = {4'd0, a} + {4'd0, b} + {4'd0, cin};
        endcase
    end

    assign quot = div10(sum);
    assign rem  = sum - ({3'd0, quot} * 8'd10);

    always_comb
    begin
        unique case (op)
            ALU_SUB:
            begin
                if ({1'b0, a} >= sub_y) begin
                    res.digit = NIB_W'({1'b0, a} - sub_y);
                    res.carry = '0;
                end
                else begin
                    res.digit = NIB_W'({1'b0, a} + 5'd10 - sub_y);
                    res.carry = NIB_W'(1);
                end
            end
            default:
            begin
                res.digit = rem[NIB_W-1:0];
                res.carry = quot[NIB_W-1:0];
            end
        endcase
    end

endmodule

FILE: hw/rtl/signed_decimal_add_sub_mul.sv
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul
// Sign-magnitude BCD add, subtract and multiply over DIGITS digits,
// computed one decimal digit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries operand words of 16 BCD digits, least significant first.
//   Each transfer stores one word; the transfer with last_word set is the
//   most significant word, carries signs and command and starts the work.
//   out_ch then presents WORDS result words, least significant first, with
//   last_result on the final one; sign, overflow and bad_digit repeat.
// Operation (after the last operand word):
//   add:       one digit step per cycle over DIGITS digits.
//   subtract:  one or two passes; a second pass runs when B > A.
//   multiply:  one digit product per cycle in a single shared digit unit,
//              plus a carry and a realign step per row, over DIGITS rows.
//   bad digit: no computation, the zero result is emitted at once.
//   One operation is in flight at a time; in_ch is not ready from the last
//   word until the final result transfer.
// Reset clears the operand stores, word counters and bad-digit flag; nothing is emitted.
// A stalled receiver simply holds the current result word on out_ch.
// ----------------------------------------------------------------------------
module signed_decimal_add_sub_mul
    import sdas_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sdas_in_if.sink      in_ch,
    sdas_out_if.source   out_ch
);

    typedef enum logic [6:0] {
        ST_COLLECT = 7'b0000001,
        ST_ADD     = 7'b0000010,
        ST_SUB     = 7'b0000100,
        ST_MUL     = 7'b0001000,
        ST_MULC    = 7'b0010000,
        ST_SWAP    = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } state_t;

    state_t              state_reg;
    logic [WORD_W-1:0]   store_a_reg [WORDS];
    logic [WORD_W-1:0]   store_b_reg [WORDS];
    logic [WIDX_W-1:0]   word_count_reg;
    logic                bad_reg;
    logic [MAG_W-1:0]    a_reg;
    logic [MAG_W-1:0]    b_reg;
    logic [PROD_W-1:0]   r_reg;
    logic [NIB_W-1:0]    carry_reg;
    logic [DCNT_W-1:0]   dig_reg;
    logic [DCNT_W-1:0]   row_reg;
    logic                sa_reg;
    logic                sb_reg;
    logic                sbe_reg;
    logic                swap_reg;
    logic                sign_reg;
    logic                ovf_reg;
    logic [WIDX_W-1:0]   out_word_reg;

    logic                in_xfer;
    logic                out_xfer;
    logic                bad_now;
    logic                sb_eff;
    logic [MAG_W-1:0]    full_a;
    logic [MAG_W-1:0]    full_b;
    logic                last_digit;

    alu_op_t             alu_op;
    logic [NIB_W-1:0]    alu_a;
    logic [NIB_W-1:0]    alu_b;
    alu_res_t            alu_res;

    assign in_ch.ready = (state_reg == ST_COLLECT);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (state_reg == ST_EMIT);
    assign out_xfer    = out_ch.valid && out_ch.ready;

    // Output word is a registered slice of the upper product half.
    assign out_ch.result_digits = r_reg[MAG_W + out_word_reg * WORD_W +: WORD_W];
    assign out_ch.result_sign   = sign_reg;
    assign out_ch.overflow      = ovf_reg;
    assign out_ch.bad_digit     = bad_reg;
    assign out_ch.last_result   = (out_word_reg == WIDX_W'(WORDS - 1));

    assign bad_now = bad_reg || word_has_bad(in_ch.digits_a) || word_has_bad(in_ch.digits_b);
    assign sb_eff  = in_ch.sign_b ^ (in_ch.command == CMD_SUB);
    assign last_digit = (dig_reg == DCNT_W'(DIGITS - 1));

    // Assemble full operands: the incoming word lands at the current slot.
    always_comb
    begin
        for (int w = 0; w < WORDS; w++) begin
            if (WIDX_W'(w) == word_count_reg) begin
                full_a[w*WORD_W +: WORD_W] = in_ch.digits_a;
                full_b[w*WORD_W +: WORD_W] = in_ch.digits_b;
            end
            else begin
                full_a[w*WORD_W +: WORD_W] = store_a_reg[w];
                full_b[w*WORD_W +: WORD_W] = store_b_reg[w];
            end
        end
    end

    // Digit unit operand selection; subtract swaps operands on its second pass.
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = a_reg[NIB_W-1:0];
        alu_b  = b_reg[NIB_W-1:0];
        unique case (state_reg)
            ST_SUB:
            begin
                alu_op = ALU_SUB;
                if (swap_reg) begin
                    alu_a = b_reg[NIB_W-1:0];
                    alu_b = a_reg[NIB_W-1:0];
                end
            end
            ST_MUL:  alu_op = ALU_MUL;
            default: alu_op = ALU_ADD;
        endcase
    end

    sdas_digit_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .acc (r_reg[NIB_W-1:0]),
        .cin (carry_reg),
        .res (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_COLLECT;
            word_count_reg <= '0;
            bad_reg        <= 1'b0;
            out_word_reg   <= '0;
            for (int w = 0; w < WORDS; w++) begin
                store_a_reg[w] <= '0;
                store_b_reg[w] <= '0;
            end
        end
        else begin
            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (in_xfer) begin
                        bad_reg <= bad_now;
                        if (!in_ch.last_word) begin
                            // Hold the word; the slot saturates at the top word.
                            store_a_reg[word_count_reg] <= in_ch.digits_a;
                            store_b_reg[word_count_reg] <= in_ch.digits_b;
                            if (word_count_reg != WIDX_W'(WORDS - 1)) begin
                                word_count_reg <= word_count_reg + 1'b1;
                            end
                        end
                        else if (bad_now) begin
                            state_reg <= ST_EMIT;
                        end
                        else if (in_ch.command[1]) begin
                            state_reg <= ST_MUL;
                        end
                        else if (in_ch.sign_a == sb_eff) begin
                            state_reg <= ST_ADD;
                        end
                        else begin
                            state_reg <= ST_SUB;
                        end
                    end
                end
                ST_ADD:
                begin
                    if (last_digit) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SUB:
                begin
                    if (last_digit && (swap_reg || alu_res.carry == '0)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_MUL:
                begin
                    if (last_digit) begin
                        state_reg <= ST_MULC;
                    end
                end
                ST_MULC:
                begin
                    state_reg <= ST_SWAP;
                end
                ST_SWAP:
                begin
                    if (row_reg == DCNT_W'(DIGITS - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                    else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    if (out_xfer) begin
                        if (out_word_reg == WIDX_W'(WORDS - 1)) begin
                            // Drop the operation: clear stores, counters and the bad-digit flag.
                            out_word_reg   <= '0;
                            word_count_reg <= '0;
                            bad_reg        <= 1'b0;
                            for (int w = 0; w < WORDS; w++) begin
                                store_a_reg[w] <= '0;
                                store_b_reg[w] <= '0;
                            end
                            state_reg <= ST_COLLECT;
                        end
                        else begin
                            out_word_reg <= out_word_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    // Datapath: digit shift registers, counters and result flags.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_xfer && in_ch.last_word) begin
                    a_reg     <= full_a;
                    b_reg     <= full_b;
                    r_reg     <= '0;
                    carry_reg <= '0;
                    dig_reg   <= '0;
                    row_reg   <= '0;
                    sa_reg    <= in_ch.sign_a;
                    sb_reg    <= in_ch.sign_b;
                    sbe_reg   <= sb_eff;
                    swap_reg  <= 1'b0;
                    sign_reg  <= 1'b1;
                    ovf_reg   <= 1'b0;
                end
            end
            ST_ADD:
            begin
                a_reg     <= {a_reg[NIB_W-1:0], a_reg[MAG_W-1:NIB_W]};
                b_reg     <= {b_reg[NIB_W-1:0], b_reg[MAG_W-1:NIB_W]};
                r_reg     <= {alu_res.digit, r_reg[PROD_W-1:NIB_W]};
                carry_reg <= alu_res.carry;
                dig_reg   <= dig_reg + 1'b1;
                if (last_digit) begin
                    ovf_reg  <= (alu_res.carry != '0);
                    sign_reg <= sa_reg;
                end
            end
            ST_SUB:
            begin
                a_reg   <= {a_reg[NIB_W-1:0], a_reg[MAG_W-1:NIB_W]};
                b_reg   <= {b_reg[NIB_W-1:0], b_reg[MAG_W-1:NIB_W]};
                r_reg   <= {alu_res.digit, r_reg[PROD_W-1:NIB_W]};
                dig_reg <= dig_reg + 1'b1;
                if (last_digit) begin
                    carry_reg <= '0;
                    if (!swap_reg && alu_res.carry != '0) begin
                        // A < B: rerun as B - A.
                        swap_reg <= 1'b1;
                    end
                    else begin
                        sign_reg <= swap_reg ? sbe_reg : sa_reg;
                        ovf_reg  <= 1'b0;
                    end
                end
                else begin
                    carry_reg <= alu_res.carry;
                end
            end
            ST_MUL:
            begin
                b_reg     <= {b_reg[NIB_W-1:0], b_reg[MAG_W-1:NIB_W]};
                r_reg     <= {alu_res.digit, r_reg[PROD_W-1:NIB_W]};
                carry_reg <= alu_res.carry;
                dig_reg   <= dig_reg + 1'b1;
            end
            ST_MULC:
            begin
                r_reg     <= {carry_reg, r_reg[PROD_W-1:NIB_W]};
                carry_reg <= '0;
            end
            ST_SWAP:
            begin
                // Realign the partial product to the next row's start digit.
                r_reg   <= {r_reg[MAG_W-1:0], r_reg[PROD_W-1:MAG_W]};
                a_reg   <= {a_reg[NIB_W-1:0], a_reg[MAG_W-1:NIB_W]};
                row_reg <= row_reg + 1'b1;
                if (row_reg == DCNT_W'(DIGITS - 1)) begin
                    ovf_reg  <= |r_reg[PROD_W-1:MAG_W];
                    sign_reg <= (sa_reg == sb_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: verif/signed_decimal_add_sub_mul_test.sv
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul_test
// Self-checking bench for the sign-magnitude BCD add/subtract/multiply unit.
// Operand words stream in through a queue-fed driver with random gaps. A
// digit-level predictor computes the result words of every operation. The
// monitor compares each result transfer, with random stalls, against them.
// ----------------------------------------------------------------------------
module signed_decimal_add_sub_mul_test
    import sdas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One operand word as the driver presents it.
    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] digits_a;
        logic [WORD_W-1:0] digits_b;
        logic              sign_a;
        logic              sign_b;
        logic              last_word;
    } operand_word_t;

    // One result word as the block should emit it.
    typedef struct {
        logic [WORD_W-1:0] result_digits;
        logic              result_sign;
        logic              overflow;
        logic              bad_digit;
        logic              last_result;
    } result_word_t;

    logic clk;
    logic rst_n;

    sdas_in_if  in_ch ();
    sdas_out_if out_ch ();

    signed_decimal_add_sub_mul uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    operand_word_t pending_words[$];
    result_word_t  expected_results[$];

    // Predictor state: operand stores, word position and bad-nibble flag.
    logic [WORD_W-1:0] store_a[WORDS];
    logic [WORD_W-1:0] store_b[WORDS];
    int                word_pos;
    bit                bad_nibble_seen;

    int  mismatches;
    bit  hold_sender;
    int  send_gap;
    int  stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit nibble_over_nine(logic [WORD_W-1:0] w);
        for (int i = 0; i < WORD_DIG; i++)
        begin
            if (w[i*4 +: 4] > 4'd9)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Store one accepted operand word; on the last word compute the result
    // words and queue them, then clear the stores.
    task automatic predict_word(operand_word_t w);
        int      dig_a[DIGITS];
        int      dig_b[DIGITS];
        int      dig_r[DIGITS];
        int      prod[2*DIGITS];
        int      cmp;
        int      carry;
        int      t;
        bit      ovf;
        bit      sgn;
        bit      sb;
        result_word_t r;

        store_a[word_pos] = w.digits_a;
        store_b[word_pos] = w.digits_b;
        if (nibble_over_nine(w.digits_a) || nibble_over_nine(w.digits_b))
            bad_nibble_seen = 1'b1;
        if (!w.last_word)
        begin
            // Advance but saturate at the top word.
            if (word_pos < WORDS - 1)
                word_pos++;
            return;
        end

        for (int i = 0; i < DIGITS; i++)
        begin
            dig_a[i] = store_a[i/16][(i%16)*4 +: 4];
            dig_b[i] = store_b[i/16][(i%16)*4 +: 4];
            dig_r[i] = 0;
        end
        ovf = 1'b0;
        sgn = 1'b1;
        if (w.command[1])
        begin
            for (int i = 0; i < 2*DIGITS; i++)
                prod[i] = 0;
            for (int i = 0; i < DIGITS; i++)
                for (int j = 0; j < DIGITS; j++)
                    prod[i+j] += dig_a[i] * dig_b[j];
            carry = 0;
            for (int i = 0; i < 2*DIGITS; i++)
            begin
                t = prod[i] + carry;
                carry = t / 10;
                if (i < DIGITS)
                    dig_r[i] = t % 10;
                else if (t % 10 != 0)
                    ovf = 1'b1;
            end
            if (carry != 0)
                ovf = 1'b1;
            sgn = (w.sign_a == w.sign_b);
        end
        else
        begin
            sb = w.sign_b ^ (w.command == CMD_SUB);
            if (w.sign_a == sb)
            begin
                carry = 0;
                for (int i = 0; i < DIGITS; i++)
                begin
                    t = dig_a[i] + dig_b[i] + carry;
                    carry = t / 10;
                    dig_r[i] = t % 10;
                end
                ovf = (carry != 0);
                sgn = w.sign_a;
            end
            else
            begin
                cmp = 0;
                for (int i = DIGITS - 1; i >= 0 && cmp == 0; i--)
                    cmp = (dig_a[i] > dig_b[i]) ? 1 : (dig_a[i] < dig_b[i]) ? -1 : 0;
                // Larger minus smaller; equal magnitudes keep A's sign.
                carry = 0;
                for (int i = 0; i < DIGITS; i++)
                begin
                    t = (cmp >= 0) ? dig_a[i] - dig_b[i] - carry
                                   : dig_b[i] - dig_a[i] - carry;
                    carry = (t < 0);
                    dig_r[i] = (t < 0) ? t + 10 : t;
                end
                sgn = (cmp >= 0) ? w.sign_a : sb;
            end
        end

        for (int k = 0; k < WORDS; k++)
        begin
            for (int i = 0; i < 16; i++)
                r.result_digits[i*4 +: 4] = bad_nibble_seen ? 4'd0 : 4'(dig_r[k*16+i]);
            r.result_sign = bad_nibble_seen ? 1'b1 : sgn;
            r.overflow    = bad_nibble_seen ? 1'b0 : ovf;
            r.bad_digit   = bad_nibble_seen;
            r.last_result = (k == WORDS - 1);
            expected_results.push_back(r);
        end
        for (int k = 0; k < WORDS; k++)
        begin
            store_a[k] = '0;
            store_b[k] = '0;
        end
        word_pos = 0;
        bad_nibble_seen = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_bcd_word(int top_digit);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i <= top_digit; i++)
            w[i*4 +: 4] = 4'($urandom_range(9));
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_operand();
        case ($urandom_range(5))
            0:       return '0;
            1:       return {16{4'h9}};
            2:       return random_bcd_word($urandom_range(3));
            default: return random_bcd_word(15);
        endcase
    endfunction

    task automatic queue_word(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] a,
                              logic [WORD_W-1:0] b, bit sa, bit sb, bit last);
        operand_word_t w;
        w.command   = cmd;
        w.digits_a  = a;
        w.digits_b  = b;
        w.sign_a    = sa;
        w.sign_b    = sb;
        w.last_word = last;
        pending_words.push_back(w);
    endtask

    // Full operation of WORDS words; lower words carry random command/sign noise.
    task automatic queue_operation(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] a[WORDS],
                                   logic [WORD_W-1:0] b[WORDS], bit sa, bit sb);
        for (int k = 0; k < WORDS; k++)
            queue_word(k == WORDS - 1 ? cmd : CMD_W'($urandom_range(3)), a[k], b[k],
                       k == WORDS - 1 ? sa : 1'($urandom), k == WORDS - 1 ? sb : 1'($urandom),
                       k == WORDS - 1);
    endtask

    // Driver: present queued words with random gaps between transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.command   <= CMD_ADD;
            in_ch.digits_a  <= '0;
            in_ch.digits_b  <= '0;
            in_ch.sign_a    <= 1'b1;
            in_ch.sign_b    <= 1'b1;
            in_ch.last_word <= 1'b0;
            send_gap        <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            // Predict on the transfer, then load the next word or drop valid.
            if (in_ch.valid)
                predict_word('{in_ch.command, in_ch.digits_a, in_ch.digits_b,
                               in_ch.sign_a, in_ch.sign_b, in_ch.last_word});
            if (send_gap > 0 || hold_sender || pending_words.size() == 0)
            begin
                in_ch.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                operand_word_t w;
                w = pending_words.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.command   <= w.command;
                in_ch.digits_a  <= w.digits_a;
                in_ch.digits_b  <= w.digits_b;
                in_ch.sign_a    <= w.sign_a;
                in_ch.sign_b    <= w.sign_b;
                in_ch.last_word <= w.last_word;
                send_gap        <= ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
            end
        end
    end

    // Monitor: random stalls on ready, check every result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_word_t e;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: digits=%h sign=%b",
                                 out_ch.result_digits, out_ch.result_sign);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_ch.result_digits !== e.result_digits
                        || out_ch.result_sign !== e.result_sign
                        || out_ch.overflow !== e.overflow
                        || out_ch.bad_digit !== e.bad_digit
                        || out_ch.last_result !== e.last_result)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp %h s%b o%b b%b l%b got %h s%b o%b b%b l%b",
                                     e.result_digits, e.result_sign, e.overflow,
                                     e.bad_digit, e.last_result, out_ch.result_digits,
                                     out_ch.result_sign, out_ch.overflow,
                                     out_ch.bad_digit, out_ch.last_result);
                    end
                end
            end
            // Hold ready low for a drawn number of cycles, then raise it.
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (out_ch.valid && out_ch.ready && $urandom_range(2) != 0)
            begin
                stall_left   <= $urandom_range(14);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [WORD_W-1:0] a[WORDS];
        logic [WORD_W-1:0] b[WORDS];
        int words_queued;
        int short_len;

        for (int k = 0; k < WORDS; k++)
        begin
            store_a[k] = '0;
            store_b[k] = '0;
        end
        word_pos        = 0;
        bad_nibble_seen = 1'b0;
        mismatches      = 0;
        hold_sender     = 1'b0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, each command, negative zero, short operands,
        // bad nibbles, overrun of the word position, unused command code.
        for (int k = 0; k < WORDS; k++)
        begin
            a[k] = {16{4'h9}};
            b[k] = {16{4'h9}};
        end
        queue_operation(CMD_ADD, a, b, 1, 1);             // add overflow
        queue_operation(CMD_MUL, a, b, 0, 1);             // multiply overflow, negative
        queue_operation(CMD_SUB, a, b, 0, 0);             // equal magnitudes: negative zero
        queue_operation(CMD_SUB, a, b, 1, 1);
        queue_operation(2'd3, a, b, 1, 0);                // code 3 behaves as multiply
        for (int k = 0; k < WORDS; k++)
        begin
            a[k] = '0;
            b[k] = random_bcd_word(15);
        end
        queue_operation(CMD_MUL, a, b, 1, 0);             // zero times value, unlike signs
        queue_operation(CMD_ADD, a, b, 1, 0);             // B larger: second pass
        queue_word(CMD_ADD, 64'h1234, 64'h99, 1, 0, 1);   // one-word operands
        queue_word(CMD_SUB, 64'h5, 64'h7, 0, 1, 0);
        queue_word(CMD_SUB, 64'h12, 64'h3, 0, 1, 1);      // two-word operands
        queue_word(CMD_ADD, {16{4'hF}}, 64'h1, 1, 1, 1);  // bad nibble on A
        queue_word(CMD_ADD, 64'h1, 64'hA000_0000_0000_0000, 1, 1, 0);
        queue_word(CMD_MUL, 64'h2, 64'h3, 1, 1, 1);       // bad nibble in a lower word
        for (int k = 0; k < WORDS + 2; k++)               // more words than positions
            queue_word(CMD_ADD, random_bcd_word(15), random_bcd_word(15), 1, 1,
                       k == WORDS + 1);

        // Pause the sender until the directed results have all arrived.
        while (pending_words.size() != 0 || in_ch.valid)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        // Random: mostly full operations, some short, overlong or corrupted.
        words_queued = 0;
        while (words_queued < 340)
        begin
            for (int k = 0; k < WORDS; k++)
            begin
                a[k] = random_operand();
                b[k] = random_operand();
                if ($urandom_range(19) == 0)
                    a[k] = {$urandom, $urandom};
                if ($urandom_range(19) == 0)
                    b[k] = {$urandom, $urandom};
            end
            case ($urandom_range(9))
                0:
                begin
                    short_len = $urandom_range(1, WORDS - 1);
                    for (int k = 0; k < short_len; k++)
                        queue_word(CMD_W'($urandom_range(3)), a[k], b[k], 1'($urandom),
                                   1'($urandom), k == short_len - 1);
                end
                1:
                begin
                    for (int k = 0; k <= WORDS; k++)
                        queue_word(CMD_W'($urandom_range(3)), a[k % WORDS], b[k % WORDS],
                                   1'($urandom), 1'($urandom), k == WORDS);
                end
                default:
                    queue_operation(($urandom_range(4) == 0) ? CMD_MUL
                                    : CMD_W'($urandom_range(1)), a, b,
                                    1'($urandom), 1'($urandom));
            endcase
            words_queued = words_queued + WORDS;
        end

        while (pending_words.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
